// ===== rtl/core/caf_pkg.sv =====
// ----------------------------------------------------------------------------
// caf_pkg: shared types and constants of the complementary attitude filter
// Holds the sequencer state type, datapath widths, register indexes and the
// arctangent table used by the CORDIC vectoring iterations.
// ----------------------------------------------------------------------------
package caf_pkg;

	// Number of CORDIC iterations per angle (valid range 8 to 24).
	localparam int CORDIC_STEPS = 16;

	// Step counter width; it must index up to 24 iterations.
	localparam int STEP_W = 5;

	// Digit steps of the square root: a 48-bit radicand gives 24 result bits.
	localparam int ROOT_STEPS = 24;
	localparam int SQUARE_LAST = 2;
	localparam int BLEND_LAST = 5;

	// Datapath widths.
	localparam int VEC_W = 28;   // CORDIC vector components
	localparam int ANG_W = 26;   // angles in 2^-16 degree
	localparam int ST_W = 25;    // filter state in 2^-16 degree
	localparam int PRED_W = 37;  // gyro prediction in 2^-24 degree
	localparam int ACC_W = 54;   // blend accumulator
	localparam int MA_W = 27;    // multiplier operand A
	localparam int MB_W = 21;    // multiplier operand B
	localparam int PROD_W = MA_W + MB_W;

	localparam logic [16:0] ALPHA_ONE = 17'd65536;
	localparam logic signed [ANG_W-1:0] QUARTER_TURN = 26'sd5898240;

	// Configuration register indexes.
	localparam logic REG_BLEND_WEIGHT = 1'b0;
	localparam logic REG_SAMPLE_PERIOD = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT,
		ST_ROLL,
		ST_PITCH,
		ST_BLEND,
		ST_FINISH
	} caf_state_t;

	// atan(2^-i) in units of 2^-16 degree.
	function automatic logic signed [ANG_W-1:0] atan_step(input logic [STEP_W-1:0] i);
		logic signed [ANG_W-1:0] a;
		unique case (i)
			5'd0:    a = 26'sd2949120;
			5'd1:    a = 26'sd1740967;
			5'd2:    a = 26'sd919879;
			5'd3:    a = 26'sd466945;
			5'd4:    a = 26'sd234379;
			5'd5:    a = 26'sd117304;
			5'd6:    a = 26'sd58666;
			5'd7:    a = 26'sd29335;
			5'd8:    a = 26'sd14668;
			5'd9:    a = 26'sd7334;
			5'd10:   a = 26'sd3667;
			5'd11:   a = 26'sd1833;
			5'd12:   a = 26'sd917;
			5'd13:   a = 26'sd458;
			5'd14:   a = 26'sd229;
			5'd15:   a = 26'sd115;
			5'd16:   a = 26'sd57;
			5'd17:   a = 26'sd29;
			5'd18:   a = 26'sd14;
			5'd19:   a = 26'sd7;
			5'd20:   a = 26'sd4;
			5'd21:   a = 26'sd2;
			5'd22:   a = 26'sd1;
			default: a = 26'sd0;
		endcase
		return a;
	endfunction

endpackage

// ===== rtl/core/complementary_attitude_filter.sv =====
// ----------------------------------------------------------------------------
// complementary_attitude_filter: roll and pitch from one IMU sample per item
// Accelerometer angles come from CORDIC vectoring (atan2) and a digit-by-digit
// square root; the gyro prediction and the accelerometer angle are blended
// with a weight alpha on one shared multiplier.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  ----------------------------------
//  cfg      in         cfg_we               cfg_index, cfg_data[19:0]
//  in       in         in_valid / in_stall  accel_x/y/z, roll_rate, pitch_rate
//  out      out        out_valid/out_stall  roll_angle, pitch_angle,
//                                           roll_from_gravity,
//                                           pitch_from_gravity, first_sample
//
// One item is taken at a time: the sequencer runs from acceptance until it is
// idle again, and only then can the next item be taken. A sample that loads
// the initial angles, or arrives with a zero sample period, skips the blend.
// An item passes in turn through the sum of squares, the square root at one
// result bit a cycle, the two CORDIC passes on the single vectoring unit,
// the blend on the one multiplier and the hand-over of the result to the
// output register. in_stall is high whenever the sequencer is busy.
// The finished result waits in the output register, so a stalled output
// delays the next acceptance only if a second item finishes meanwhile.
// Reset clears the filter state and the started flag and returns the
// configuration registers to their default values.
//
// ----------------------------------------------------------------------------
module complementary_attitude_filter
	import caf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [19:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  accel_x,
	input  logic signed [15:0]  accel_y,
	input  logic signed [15:0]  accel_z,
	input  logic signed [15:0]  roll_rate,
	input  logic signed [15:0]  pitch_rate,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  roll_angle,
	output logic signed [15:0]  pitch_angle,
	output logic signed [15:0]  roll_from_gravity,
	output logic signed [14:0]  pitch_from_gravity,
	output logic                first_sample
);

	// Bounds of the filter state and of the accelerometer angle outputs.
	localparam logic signed [29:0] STATE_HI = 30'sd16777215;
	localparam logic signed [29:0] STATE_LO = -30'sd16777216;
	localparam logic signed [17:0] ROLL_LIM = 18'sd23040;
	localparam logic signed [17:0] PITCH_LIM = 18'sd11520;

	// Sequencer.
	caf_state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic axis_q;
	logic step_inc, step_clr, load_roll, load_pitch, out_load, accept;
	logic step_last;

	// Configuration.
	logic [16:0] weight_q;
	logic [19:0] period_q;
	logic [16:0] alpha, beta;

	// Captured sample.
	logic signed [15:0] ax_q, ay_q, az_q, rr_q, pr_q;

	// Sum of squares and square root.
	logic [31:0] rad_q;
	logic [25:0] rem_q;
	logic [23:0] root_q;
	logic [27:0] rem_t, trial;

	// CORDIC vectoring unit.
	logic signed [VEC_W-1:0] cx_q, cy_q, src_x, src_y, rot_x, rot_y;
	logic signed [VEC_W-1:0] sh_x, sh_y, nx, ny;
	logic signed [ANG_W-1:0] cz_q, rot_z, nz, cordic_res;
	logic zero_q;
	logic signed [ANG_W-1:0] roll_g_q, pitch_g_q;

	// Filter state and blend datapath.
	logic signed [ST_W-1:0] roll_st_q, pitch_st_q, cur_st;
	logic started_q, first_q;
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p, prod_q;
	logic signed [PRED_W-1:0] pred_q;
	logic signed [ACC_W-1:0] acc_q, acc_r;
	logic signed [29:0] blend_q30;
	logic signed [ST_W-1:0] blend_sat;
	logic signed [15:0] cur_rate;
	logic signed [ANG_W-1:0] cur_grav;

	// Output register.
	logic out_valid_q;

	// Filter state rounded to 1/128 degree and saturated to 16 bits.
	function automatic logic signed [15:0] angle_out(input logic signed [ST_W-1:0] s);
		logic signed [ST_W:0] t;
		logic signed [16:0] v;
		t = $signed({s[ST_W-1], s}) + (ST_W+1)'(256);
		v = t[ST_W:9];
		if (v > 17'sd32767) begin
			return 16'sh7fff;
		end else if (v < -17'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	// Accelerometer angle rounded to 1/128 degree and clamped to +-lim.
	function automatic logic signed [15:0] gravity_out(input logic signed [ANG_W-1:0] g,
			input logic signed [17:0] lim);
		logic signed [ANG_W:0] t;
		logic signed [17:0] v;
		t = $signed({g[ANG_W-1], g}) + (ANG_W+1)'(256);
		v = t[ANG_W:9];
		if (v > lim) begin
			v = lim;
		end else if (v < -lim) begin
			v = -lim;
		end
		return v[15:0];
	endfunction

	assign accept = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	assign alpha = (weight_q > ALPHA_ONE) ? ALPHA_ONE : weight_q;
	assign beta = ALPHA_ONE - alpha;

	// ------------------------------------------------------------------
	// Sequencer: state register and next-state logic.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		step_inc = 1'b0;
		step_clr = 1'b0;
		load_roll = 1'b0;
		load_pitch = 1'b0;
		out_load = 1'b0;
		step_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SQUARE;
					step_clr = 1'b1;
				end
			end
			ST_SQUARE: begin
				step_last = (step_q == STEP_W'(SQUARE_LAST));
				if (step_last) begin
					state_d = ST_ROOT;
					step_clr = 1'b1;
				end else begin
					step_inc = 1'b1;
				end
			end
			ST_ROOT: begin
				step_last = (step_q == STEP_W'(ROOT_STEPS - 1));
				if (step_last) begin
					state_d = ST_ROLL;
					step_clr = 1'b1;
					load_roll = 1'b1;
				end else begin
					step_inc = 1'b1;
				end
			end
			ST_ROLL: begin
				step_last = (step_q == STEP_W'(CORDIC_STEPS - 1));
				if (step_last) begin
					state_d = ST_PITCH;
					step_clr = 1'b1;
					load_pitch = 1'b1;
				end else begin
					step_inc = 1'b1;
				end
			end
			ST_PITCH: begin
				step_last = (step_q == STEP_W'(CORDIC_STEPS - 1));
				if (step_last) begin
					step_clr = 1'b1;
					// A zero period or the very first sample needs no blend.
					if (period_q == '0 || !started_q) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_BLEND;
					end
				end else begin
					step_inc = 1'b1;
				end
			end
			ST_BLEND: begin
				step_last = (step_q == STEP_W'(BLEND_LAST));
				if (step_last) begin
					step_clr = 1'b1;
					if (axis_q) begin
						state_d = ST_FINISH;
					end
				end else begin
					step_inc = 1'b1;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
					out_load = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			axis_q <= 1'b0;
		end else begin
			if (step_clr) begin
				step_q <= '0;
			end else if (step_inc) begin
				step_q <= step_q + 1'b1;
			end
			if (accept) begin
				axis_q <= 1'b0;
			end else if (state_q == ST_BLEND && step_last) begin
				axis_q <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= 17'd64225;
			period_q <= 20'd10486;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BLEND_WEIGHT:  weight_q <= cfg_data[16:0];
				REG_SAMPLE_PERIOD: period_q <= cfg_data;
				default:           period_q <= period_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Shared multiplier. Squares during ST_SQUARE; during the blend it
	// forms rate*period, grav*(1-alpha), and alpha*pred in two halves.
	// ------------------------------------------------------------------
	assign cur_rate = axis_q ? pr_q : rr_q;
	assign cur_grav = axis_q ? pitch_g_q : roll_g_q;
	assign cur_st = axis_q ? pitch_st_q : roll_st_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_SQUARE) begin
			if (step_q == '0) begin
				mul_a = MA_W'(ay_q);
				mul_b = MB_W'(ay_q);
			end else begin
				mul_a = MA_W'(az_q);
				mul_b = MB_W'(az_q);
			end
		end else if (state_q == ST_BLEND) begin
			unique case (step_q)
				STEP_W'(0): begin
					mul_a = MA_W'(cur_rate);
					mul_b = $signed({1'b0, period_q});
				end
				STEP_W'(1): begin
					mul_a = MA_W'(cur_grav);
					mul_b = $signed({4'd0, beta});
				end
				STEP_W'(2): begin
					mul_a = $signed({7'd0, pred_q[19:0]});
					mul_b = $signed({4'd0, alpha});
				end
				STEP_W'(3): begin
					mul_a = MA_W'($signed(pred_q[PRED_W-1:20]));
					mul_b = $signed({4'd0, alpha});
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
	end

	assign mul_p = mul_a * mul_b;

	// ------------------------------------------------------------------
	// Square root, one result bit per cycle (restoring, two radicand bits
	// brought down each step). The radicand's low 16 zero bits follow as
	// zeros shifted into rad_q.
	// ------------------------------------------------------------------
	assign rem_t = {rem_q, rad_q[31:30]};
	assign trial = {2'b00, root_q, 2'b01};

	// ------------------------------------------------------------------
	// CORDIC vectoring: pre-rotation by +-90 degrees for a negative x, then
	// one micro-rotation per cycle.
	// ------------------------------------------------------------------
	always_comb begin
		if (load_pitch) begin
			src_y = -({{(VEC_W-16){ax_q[15]}}, ax_q} <<< 8);
			src_x = $signed({{(VEC_W-24){1'b0}}, root_q});
		end else begin
			src_y = $signed({{(VEC_W-24){ay_q[15]}}, ay_q, 8'd0});
			src_x = $signed({{(VEC_W-24){az_q[15]}}, az_q, 8'd0});
		end
		rot_x = src_x;
		rot_y = src_y;
		rot_z = '0;
		if (src_x < 0) begin
			if (src_y >= 0) begin
				rot_x = src_y;
				rot_y = -src_x;
				rot_z = QUARTER_TURN;
			end else begin
				rot_x = -src_y;
				rot_y = src_x;
				rot_z = -QUARTER_TURN;
			end
		end
	end

	assign sh_x = cx_q >>> step_q;
	assign sh_y = cy_q >>> step_q;

	always_comb begin
		if (cy_q > 0) begin
			nx = cx_q + sh_y;
			ny = cy_q - sh_x;
			nz = cz_q + atan_step(step_q);
		end else begin
			nx = cx_q - sh_y;
			ny = cy_q + sh_x;
			nz = cz_q - atan_step(step_q);
		end
	end

	// A zero vector has angle zero.
	assign cordic_res = zero_q ? '0 : nz;

	// ------------------------------------------------------------------
	// Blend rounding: (acc + 2^23) >> 24, saturated to the state range.
	// ------------------------------------------------------------------
	assign acc_r = acc_q + (ACC_W'(1) <<< 23);
	assign blend_q30 = acc_r[ACC_W-1:24];

	always_comb begin
		if (blend_q30 > STATE_HI) begin
			blend_sat = STATE_HI[ST_W-1:0];
		end else if (blend_q30 < STATE_LO) begin
			blend_sat = STATE_LO[ST_W-1:0];
		end else begin
			blend_sat = blend_q30[ST_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers (no reset needed).
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			ax_q <= accel_x;
			ay_q <= accel_y;
			az_q <= accel_z;
			rr_q <= roll_rate;
			pr_q <= pitch_rate;
		end

		prod_q <= mul_p;

		if (state_q == ST_SQUARE) begin
			if (step_q == STEP_W'(1)) begin
				rad_q <= prod_q[31:0];
			end else if (step_q == STEP_W'(SQUARE_LAST)) begin
				rad_q <= rad_q + prod_q[31:0];
			end
			rem_q <= '0;
			root_q <= '0;
		end else if (state_q == ST_ROOT) begin
			rad_q <= {rad_q[29:0], 2'b00};
			if (rem_t >= trial) begin
				rem_q <= rem_t[25:0] - trial[25:0];
				root_q <= {root_q[22:0], 1'b1};
			end else begin
				rem_q <= rem_t[25:0];
				root_q <= {root_q[22:0], 1'b0};
			end
		end

		if (load_roll || load_pitch) begin
			cx_q <= rot_x;
			cy_q <= rot_y;
			cz_q <= rot_z;
			zero_q <= (src_x == '0) && (src_y == '0);
		end else if (state_q == ST_ROLL || state_q == ST_PITCH) begin
			cx_q <= nx;
			cy_q <= ny;
			cz_q <= nz;
		end

		if (state_q == ST_ROLL && step_last) begin
			roll_g_q <= cordic_res;
		end
		if (state_q == ST_PITCH && step_last) begin
			pitch_g_q <= cordic_res;
		end

		if (state_q == ST_BLEND) begin
			unique case (step_q)
				STEP_W'(1): pred_q <= (PRED_W'(cur_st) <<< 8) + $signed(prod_q[PRED_W-1:0]);
				STEP_W'(2): acc_q <= ACC_W'(prod_q) <<< 8;
				STEP_W'(3): acc_q <= acc_q + ACC_W'(prod_q);
				STEP_W'(4): acc_q <= acc_q + $signed({prod_q[ACC_W-21:0], 20'd0});
				default: acc_q <= acc_q;
			endcase
		end

		if (out_load) begin
			roll_angle <= angle_out(roll_st_q);
			pitch_angle <= angle_out(pitch_st_q);
			roll_from_gravity <= gravity_out(roll_g_q, ROLL_LIM);
			pitch_from_gravity <= 15'(gravity_out(pitch_g_q, PITCH_LIM));
			first_sample <= first_q;
		end
	end

	// ------------------------------------------------------------------
	// Filter state, started flag and output valid.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_st_q <= '0;
			pitch_st_q <= '0;
			started_q <= 1'b0;
			first_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_PITCH && step_last) begin
				first_q <= (period_q != '0) && !started_q;
				if (period_q != '0 && !started_q) begin
					// Accelerometer angles stay within +-191 degrees, so they
					// always fit the state range.
					roll_st_q <= roll_g_q[ST_W-1:0];
					pitch_st_q <= cordic_res[ST_W-1:0];
					started_q <= 1'b1;
				end
			end
			if (state_q == ST_BLEND && step_last) begin
				if (axis_q) begin
					pitch_st_q <= blend_sat;
				end else begin
					roll_st_q <= blend_sat;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("block not busy after taking an item");

	a_valid_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FINISH))
		else $error("result shown without a finished item");

	a_first_means_started: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && first_sample) |-> started_q)
		else $error("first_sample flagged but filter not started");

	a_cordic_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROLL || state_q == ST_PITCH) |-> (step_q < STEP_W'(CORDIC_STEPS)))
		else $error("CORDIC step counter out of range");

	a_blend_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BLEND) |-> (started_q && period_q != '0))
		else $error("blend entered without a started filter or with zero period");

endmodule
